/* sv/lidar_packet_deframer_macros.svh */
// Assertion macros for the lidar packet deframer checker.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef LIDAR_PACKET_DEFRAMER_MACROS_SVH
`define LIDAR_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication
`define LPD_ASSERT_NOW(lbl, pre, post) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (pre) |-> (post)) else $error("lpd check failed");

// next-cycle implication
`define LPD_ASSERT_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (pre) |=> (post)) else $error("lpd check failed");

`endif

/* sv/lpd_pkg.sv */
// Package for the lidar packet deframer: sizes, codes and the state type.
// No dependencies.
package lpd_pkg;
	localparam int PACKET_BYTES      = 108;
	localparam int REVOLUTION_POINTS = 1080;
	localparam int TURN_CENTIDEG     = 36000;
	localparam int TURN_FX           = 9216000;
	localparam int START_POS         = 5;
	localparam int STOP_POS          = PACKET_BYTES - 3;
	localparam int FIRST_POINT_POS   = 7;
	localparam int POINT_STRIDE      = 6;
	localparam int ADDR_W            = $clog2(PACKET_BYTES);
	localparam int ANG_W             = 25;
	localparam int DIV_W             = 24;

	localparam logic [1:0] KIND_POINT   = 2'd0;
	localparam logic [1:0] KIND_SUM_ERR = 2'd1;
	localparam logic [1:0] KIND_HDR_ERR = 2'd2;

	localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
	localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
	localparam logic [2:0] REG_POINTS        = 3'd2;
	localparam logic [2:0] REG_MIN_RANGE     = 3'd3;
	localparam logic [2:0] REG_MAX_RANGE     = 3'd4;

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	typedef enum logic [5:0] {
		S_RX   = 6'b000001,
		S_HDR  = 6'b000010,
		S_CALC = 6'b000100,
		S_DIV  = 6'b001000,
		S_PT   = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;
endpackage

/* sv/lidar_packet_deframer.sv */
// Lidar packet deframer top level: sync hunt, packet buffer, point decoder.
// Depends on lpd_pkg.
//
//  channel | signals                              | direction
//  in      | in_valid, in_ready, rx_byte          | byte in
//  out     | out_valid, out_ready, kind..last     | result word out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write in
//
// Bytes that do not end a packet are taken back to back. A header mismatch or
// checksum error is registered as pending, and its word is loaded once out is
// free (with the input blocked while out is full). A good packet blocks the
// input while it is decoded: header reads, a setup step, 24 divider steps, then
// for each point three reads of the packet RAM, the read latency and the load;
// the packet RAM's single read port and the bit-serial divider set the pace.
// Reset is asynchronous; no clearing pass (the buffer is always written before
// read). Out stalls hold the decoder in S_EMIT.
module lidar_packet_deframer import lpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [23:0] angle_fx,
	output logic [15:0] range_mm,
	output logic [7:0]  intensity,
	output logic [10:0] point_index,
	output logic        revolution_start,
	output logic [10:0] previous_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	// config registers
	logic [7:0]  hdr1_q, hdr2_q;
	logic [4:0]  npp_q;
	logic [15:0] min_q, max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q <= 8'd170;
			hdr2_q <= 8'd85;
			npp_q  <= 5'd16;
			min_q  <= 16'd200;
			max_q  <= 16'hFFFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER_FIRST:  hdr1_q <= cfg_data[7:0];
				REG_HEADER_SECOND: hdr2_q <= cfg_data[7:0];
				REG_POINTS:        npp_q  <= cfg_data[4:0];
				REG_MIN_RANGE:     min_q  <= cfg_data;
				REG_MAX_RANGE:     max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped point count and divisor
	logic [4:0] n_pts;
	logic [3:0] div_d;
	always_comb begin
		priority if (npp_q < 5'd2) n_pts = 5'd2;
		else if (npp_q > 5'd16)    n_pts = 5'd16;
		else                       n_pts = npp_q;
	end
	assign div_d = 4'(n_pts - 5'd1);

	// control state
	state_t              state_q;
	logic [1:0]          phase_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [7:0]          sum_q;
	logic [2:0]          sub_q;
	logic [4:0]          div_cnt_q;
	logic [3:0]          pt_i_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ANG_W-1:0]    prev_ang_q;
	logic [10:0]         rev_q;
	logic                err_pend_q;
	logic [1:0]          err_kind_q;

	// datapath
	logic [31:0]         shr_q;
	logic [3:0]          rem_q;
	logic [DIV_W-1:0]    quo_q;
	logic [ANG_W-1:0]    acc_q;

	logic out_free;
	logic out_load;
	logic in_acc;
	assign out_free = !out_valid || out_ready;
	assign out_load = out_free && ((state_q == S_RX && err_pend_q) || state_q == S_EMIT);
	assign in_ready = (state_q == S_RX) && !err_pend_q;
	assign in_acc   = in_valid && in_ready;

	// packet RAM: one write port (byte intake), one registered read port
	// (decoder). Writes and reads never overlap: decode starts only after
	// the final byte is written.
	logic [7:0]        mem [PACKET_BYTES];
	logic [7:0]        rd_data_q;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              wr_en;

	always_comb begin
		unique case (phase_q)
			PH_HUNT:   wr_addr = '0;
			PH_SECOND: wr_addr = ADDR_W'(1);
			default:   wr_addr = cnt_q;
		endcase
	end
	assign wr_en = in_acc && ((phase_q == PH_HUNT && rx_byte == hdr1_q) ||
		(phase_q == PH_SECOND && rx_byte == hdr2_q) ||
		(phase_q != PH_HUNT && phase_q != PH_SECOND));

	always_comb begin
		rd_addr = base_q + ADDR_W'(sub_q[1:0]);
		if (state_q == S_HDR) begin
			unique case (sub_q[1:0])
				2'd0:    rd_addr = ADDR_W'(START_POS);
				2'd1:    rd_addr = ADDR_W'(START_POS + 1);
				2'd2:    rd_addr = ADDR_W'(STOP_POS);
				default: rd_addr = ADDR_W'(STOP_POS + 1);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= rx_byte;
		rd_data_q <= mem[rd_addr];
	end

	// angle setup: single wrap, interval
	logic [15:0] start_w, stop_w;
	logic [16:0] interval;
	always_comb begin
		start_w = (shr_q[31:16] > 16'(TURN_CENTIDEG)) ?
			16'(shr_q[31:16] - 16'(TURN_CENTIDEG)) : shr_q[31:16];
		stop_w  = (shr_q[15:0] > 16'(TURN_CENTIDEG)) ?
			16'(shr_q[15:0] - 16'(TURN_CENTIDEG)) : shr_q[15:0];
		if (start_w < stop_w) interval = {1'b0, stop_w} - {1'b0, start_w};
		else interval = 17'(TURN_CENTIDEG) + {1'b0, stop_w} - {1'b0, start_w};
	end

	// one restoring divider step
	logic [4:0] trial;
	logic       q_bit;
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign q_bit = (trial >= {1'b0, div_d});

	// point fields
	logic [ANG_W-1:0] ang;
	logic [15:0]      rng;
	logic             new_rev;
	logic [11:0]      rev_inc;
	assign ang = (acc_q > ANG_W'(TURN_FX)) ? ANG_W'(acc_q - ANG_W'(TURN_FX)) : acc_q;
	assign rng = (shr_q[23:8] < min_q || shr_q[23:8] > max_q) ? 16'd0 : shr_q[23:8];
	assign new_rev = (rev_q != 11'd0) && (ang < prev_ang_q);
	assign rev_inc = {1'b0, rev_q} + 12'd1;

	logic [7:0] sum_next;
	assign sum_next = 8'(sum_q + rx_byte);

	// out word valid: set on load, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_RX;
			phase_q    <= PH_HUNT;
			cnt_q      <= '0;
			sum_q      <= '0;
			sub_q      <= '0;
			div_cnt_q  <= '0;
			pt_i_q     <= '0;
			base_q     <= '0;
			prev_ang_q <= '0;
			rev_q      <= '0;
			err_pend_q <= 1'b0;
			err_kind_q <= KIND_POINT;
			shr_q      <= '0;
			rem_q      <= '0;
			quo_q      <= '0;
			acc_q      <= '0;
		end else begin
			unique case (state_q)
				S_RX: begin
					if (err_pend_q && out_free) begin
						err_pend_q <= 1'b0;
					end else if (in_acc) begin
						unique case (phase_q)
							PH_HUNT: begin
								if (rx_byte == hdr1_q) begin
									sum_q   <= rx_byte;
									cnt_q   <= ADDR_W'(1);
									phase_q <= PH_SECOND;
								end
							end
							PH_SECOND: begin
								if (rx_byte == hdr2_q) begin
									sum_q   <= sum_next;
									cnt_q   <= ADDR_W'(2);
									phase_q <= PH_BODY;
								end else begin
									phase_q    <= PH_HUNT;
									cnt_q      <= '0;
									err_pend_q <= 1'b1;
									err_kind_q <= KIND_HDR_ERR;
								end
							end
							default: begin
								if (cnt_q == ADDR_W'(PACKET_BYTES - 1)) begin
									phase_q <= PH_HUNT;
									cnt_q   <= '0;
									if (rx_byte != sum_q) begin
										err_pend_q <= 1'b1;
										err_kind_q <= KIND_SUM_ERR;
									end else begin
										state_q <= S_HDR;
										sub_q   <= '0;
									end
								end else begin
									sum_q <= sum_next;
									cnt_q <= ADDR_W'(cnt_q + 1'b1);
								end
							end
						endcase
					end
				end
				S_HDR: begin
					sub_q <= 3'(sub_q + 1'b1);
					if (sub_q != 3'd0) shr_q <= {shr_q[23:0], rd_data_q};
					if (sub_q == 3'd4) state_q <= S_CALC;
				end
				S_CALC: begin
					quo_q     <= {interval[15:0], 8'd0};
					rem_q     <= '0;
					div_cnt_q <= '0;
					acc_q     <= ANG_W'({start_w, 8'd0});
					state_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q     <= 4'(q_bit ? trial - {1'b0, div_d} : trial);
					quo_q     <= {quo_q[DIV_W-2:0], q_bit};
					div_cnt_q <= 5'(div_cnt_q + 1'b1);
					if (div_cnt_q == 5'(DIV_W - 1)) begin
						state_q <= S_PT;
						sub_q   <= '0;
						pt_i_q  <= '0;
						base_q  <= ADDR_W'(FIRST_POINT_POS);
					end
				end
				S_PT: begin
					sub_q <= 3'(sub_q + 1'b1);
					if (sub_q != 3'd0) shr_q <= {shr_q[23:0], rd_data_q};
					if (sub_q == 3'd3) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						prev_ang_q <= ang;
						if (new_rev) rev_q <= 11'd1;
						else if (rev_inc >= 12'(REVOLUTION_POINTS)) rev_q <= '0;
						else rev_q <= rev_inc[10:0];
						acc_q  <= ANG_W'(acc_q + ANG_W'(quo_q));
						base_q <= ADDR_W'(base_q + ADDR_W'(POINT_STRIDE));
						pt_i_q <= 4'(pt_i_q + 1'b1);
						sub_q  <= '0;
						if (pt_i_q == div_d) state_q <= S_RX;
						else state_q <= S_PT;
					end
				end
				default: state_q <= S_RX;
			endcase
		end
	end

	// output word register (payload, no reset)
	always_ff @(posedge clk) begin
		if (state_q == S_RX && err_pend_q && out_free) begin
			kind             <= err_kind_q;
			angle_fx         <= '0;
			range_mm         <= '0;
			intensity        <= '0;
			point_index      <= '0;
			revolution_start <= 1'b0;
			previous_count   <= '0;
			last             <= 1'b1;
		end else if (state_q == S_EMIT && out_free) begin
			kind             <= KIND_POINT;
			angle_fx         <= ang[23:0];
			range_mm         <= rng;
			intensity        <= shr_q[7:0];
			point_index      <= new_rev ? 11'd0 : rev_q;
			revolution_start <= new_rev;
			previous_count   <= new_rev ? rev_q : 11'd0;
			last             <= (pt_i_q == div_d);
		end
	end
endmodule

/* sv/lpd_checker.sv */
// Port-level checker for lidar_packet_deframer, bound to the top level.
// Depends on lpd_pkg and lidar_packet_deframer_macros.svh.
`include "lidar_packet_deframer_macros.svh"
module lpd_checker import lpd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [23:0] angle_fx,
	input logic [15:0] range_mm,
	input logic [10:0] point_index,
	input logic        revolution_start,
	input logic        last
);
	`LPD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(rx_byte))
	`LPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({kind, last}))
	`LPD_ASSERT_NOW(a_err_last, out_valid && kind != KIND_POINT, last && angle_fx == 24'd0)
	`LPD_ASSERT_NOW(a_err_zero, out_valid && kind != KIND_POINT, range_mm == 16'd0 && !revolution_start)
	`LPD_ASSERT_NOW(a_rev_idx, out_valid && revolution_start, point_index == 11'd0)
endmodule

bind lidar_packet_deframer lpd_checker u_lpd_checker (.*);

/* test/lidar_packet_deframer_tb.sv */
// Testbench for the lidar packet deframer: sync hunt, checksum and point decode.
// Depends on lpd_pkg and the lidar_packet_deframer RTL; self-checking, no files.
`default_nettype none
module lidar_packet_deframer_tb;
	import lpd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] angle_fx;
		logic [15:0] range_mm;
		logic [7:0]  intensity;
		logic [10:0] point_index;
		logic        revolution_start;
		logic [10:0] previous_count;
		logic        last;
	} point_word_t;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [23:0] angle_fx;
	logic [15:0] range_mm;
	logic [7:0]  intensity;
	logic [10:0] point_index;
	logic        revolution_start;
	logic [10:0] previous_count;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	lidar_packet_deframer uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of configuration and state
	logic [7:0]  hdr_first_q, hdr_second_q;
	logic [4:0]  npts_q;
	logic [15:0] min_mm_q, max_mm_q;
	logic [7:0]  pkt_bytes [PACKET_BYTES];
	int unsigned frame_pos;
	logic [1:0]  sync_phase;
	logic [7:0]  sum_acc;
	logic [23:0] last_angle;
	logic [10:0] rev_count;

	point_word_t expected_words[$];
	int fail_count = 0;
	int words_seen = 0;
	int bytes_sent = 0;
	int packets_sent = 0;
	int idle_in_pct = 0;   // sender gap chance
	int stall_out_pct = 0; // receiver stall chance
	int quiet_cycles = 0;
	bit in_done = 1'b0;

	function automatic logic [15:0] pkt_word(int pos);
		return {pkt_bytes[pos], pkt_bytes[pos + 1]};
	endfunction

	function automatic logic [31:0] wrap_cdeg(logic [31:0] v);
		return (v > TURN_CENTIDEG) ? v - TURN_CENTIDEG : v;
	endfunction

	function automatic point_word_t err_word(logic [1:0] k);
		point_word_t w = '0;
		w.kind = k;
		w.last = 1'b1;
		return w;
	endfunction

	// Decodes the buffered packet into point words and queues them.
	task automatic decode_points();
		int unsigned n, a0, a1, span, step, ang, rng;
		point_word_t w;
		n = npts_q;
		if (n < 2) n = 2;
		if (n > 16) n = 16;
		a0 = wrap_cdeg(pkt_word(START_POS));
		a1 = wrap_cdeg(pkt_word(STOP_POS));
		span = (a0 < a1) ? a1 - a0 : TURN_CENTIDEG + a1 - a0;
		step = (span * 256) / (n - 1);
		for (int i = 0; i < n; i++) begin
			ang = a0 * 256 + i * step;
			if (ang > TURN_FX) ang -= TURN_FX;
			rng = pkt_word(FIRST_POINT_POS + i * POINT_STRIDE);
			if (rng < min_mm_q || rng > max_mm_q) rng = 0;
			w = '0;
			w.kind = KIND_POINT;
			w.angle_fx = ang[23:0];
			w.range_mm = rng[15:0];
			w.intensity = pkt_bytes[FIRST_POINT_POS + 2 + i * POINT_STRIDE];
			if (rev_count != 0 && ang[23:0] < last_angle) begin
				w.revolution_start = 1'b1;
				w.previous_count = rev_count;
				w.point_index = '0;
				rev_count = 11'd1;
			end else begin
				w.point_index = rev_count;
				rev_count = (rev_count + 1 >= REVOLUTION_POINTS) ? 11'd0 : 11'(rev_count + 1);
			end
			last_angle = ang[23:0];
			w.last = (i + 1 == n);
			expected_words.push_back(w);
		end
	endtask

	// Advances the predictor by one accepted byte.
	task automatic predict_byte(logic [7:0] b);
		case (sync_phase)
			PH_HUNT: begin
				if (b == hdr_first_q) begin
					pkt_bytes[0] = b;
					sum_acc = b;
					frame_pos = 1;
					sync_phase = PH_SECOND;
				end
			end
			PH_SECOND: begin
				if (b == hdr_second_q) begin
					pkt_bytes[1] = b;
					sum_acc += b;
					frame_pos = 2;
					sync_phase = PH_BODY;
				end else begin
					sync_phase = PH_HUNT;
					frame_pos = 0;
					expected_words.push_back(err_word(KIND_HDR_ERR));
				end
			end
			default: begin
				pkt_bytes[frame_pos] = b;
				if (frame_pos < PACKET_BYTES - 1) sum_acc += b;
				frame_pos++;
				if (frame_pos == PACKET_BYTES) begin
					sync_phase = PH_HUNT;
					frame_pos = 0;
					if (pkt_bytes[PACKET_BYTES - 1] != sum_acc)
						expected_words.push_back(err_word(KIND_SUM_ERR));
					else
						decode_points();
				end
			end
		endcase
	endtask

	// Sends one byte over the input channel, with random idle cycles first.
	// Valid stays up after the handshake until the next word or wait_idle.
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Register write; only called with nothing in flight.
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEADER_FIRST:  hdr_first_q = val[7:0];
			REG_HEADER_SECOND: hdr_second_q = val[7:0];
			REG_POINTS:        npts_q = val[4:0];
			REG_MIN_RANGE:     min_mm_q = val;
			REG_MAX_RANGE:     max_mm_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Drops the input, waits until every expected word has come out, then
	// lets the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Builds a well-formed packet (optionally with a bad checksum) and sends it.
	task automatic send_packet(logic [15:0] a_start, logic [15:0] a_stop,
			bit bad_sum, bit extreme);
		logic [7:0] body [PACKET_BYTES];
		logic [7:0] s;
		body[0] = hdr_first_q;
		body[1] = hdr_second_q;
		for (int i = 2; i < PACKET_BYTES; i++)
			body[i] = extreme ? (($urandom_range(1)) ? 8'hff : 8'h00) : 8'($urandom);
		// ranges near the limits half of the time
		for (int i = 0; i < 16; i++)
			if ($urandom_range(1)) begin
				case ($urandom_range(3))
					0: {body[7 + 6*i], body[8 + 6*i]} = 16'(min_mm_q - 1);
					1: {body[7 + 6*i], body[8 + 6*i]} = min_mm_q;
					2: {body[7 + 6*i], body[8 + 6*i]} = max_mm_q;
					default: {body[7 + 6*i], body[8 + 6*i]} = 16'(max_mm_q + 1);
				endcase
			end
		{body[START_POS], body[START_POS + 1]} = a_start;
		{body[STOP_POS], body[STOP_POS + 1]} = a_stop;
		s = '0;
		for (int i = 0; i < PACKET_BYTES - 1; i++) s += body[i];
		body[PACKET_BYTES - 1] = bad_sum ? s ^ 8'(1 + $urandom_range(254)) : s;
		for (int i = 0; i < PACKET_BYTES; i++) send_byte(body[i]);
		packets_sent++;
	endtask

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(5))
			0: return 16'(TURN_CENTIDEG);
			1: return 16'(TURN_CENTIDEG + 1 + $urandom_range(29535));
			2: return 16'hffff;
			default: return 16'($urandom_range(TURN_CENTIDEG - 1));
		endcase
	endfunction

	// Checker: compare each accepted word against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			point_word_t e;
			words_seen++;
			if (expected_words.size() == 0) begin
				$error("unexpected word: kind %0d angle %0d", kind, angle_fx);
				fail_count++;
			end else begin
				e = expected_words.pop_front();
				if (kind !== e.kind) begin
					$error("kind: expected %0d got %0d", e.kind, kind); fail_count++;
				end
				if (angle_fx !== e.angle_fx) begin
					$error("angle_fx: expected %0d got %0d", e.angle_fx, angle_fx);
					fail_count++;
				end
				if (range_mm !== e.range_mm) begin
					$error("range_mm: expected %0d got %0d", e.range_mm, range_mm);
					fail_count++;
				end
				if (intensity !== e.intensity) begin
					$error("intensity: expected %0d got %0d", e.intensity, intensity);
					fail_count++;
				end
				if (point_index !== e.point_index) begin
					$error("point_index: expected %0d got %0d", e.point_index, point_index);
					fail_count++;
				end
				if (revolution_start !== e.revolution_start) begin
					$error("revolution_start: expected %0d got %0d", e.revolution_start,
						revolution_start);
					fail_count++;
				end
				if (previous_count !== e.previous_count) begin
					$error("previous_count: expected %0d got %0d", e.previous_count,
						previous_count);
					fail_count++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d got %0d", e.last, last); fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, changed on the falling edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_out_pct);

	// Watchdog on handshake progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| in_done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("lidar_packet_deframer_tb NOT OK");
			$finish;
		end
	end

	task automatic set_idling(int phase);
		case (phase % 4)
			0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
			1: begin idle_in_pct = 81; stall_out_pct = 0;  end
			2: begin idle_in_pct = 0;  stall_out_pct = 81; end
			default: begin idle_in_pct = 24; stall_out_pct = 24; end
		endcase
	endtask

	// Directed, no idling: headers, mismatch, wrap angles, checksum error.
	task automatic test_directed();
		set_idling(0);
		send_byte(8'h00);
		send_byte(hdr_first_q);
		send_byte(8'h00);               // second header mismatch
		send_byte(hdr_first_q);
		send_byte(hdr_first_q);         // repeated first byte is a mismatch too
		send_byte(8'hff);
		send_packet(16'hffff, 16'd36000, 1'b0, 1'b1);   // start wraps; stop sits on the turn
		send_packet(16'd35000, 16'd1000, 1'b1, 1'b0);   // checksum error
		wait_idle();
	endtask

	// Register extremes with a slow sender: inverted range limits, edge
	// header values and a point count at or beyond the clamp limits.
	task automatic test_config_extremes();
		logic [15:0] npts_vals [5] = '{16'd0, 16'd1, 16'd2, 16'd17, 16'd31};
		set_idling(1);
		write_reg(REG_HEADER_FIRST, 16'h00ff);
		write_reg(REG_HEADER_SECOND, 16'h0000);
		write_reg(REG_MIN_RANGE, 16'hffff);
		write_reg(REG_MAX_RANGE, 16'd0);
		write_reg(REG_POINTS, npts_vals[$urandom_range(4)]);
		send_packet(rand_angle(), rand_angle(), 1'b0, 1'b1);
		wait_idle();
	endtask

	// Random phases with receiver stalls: random settings, noise, one packet.
	task automatic test_random_traffic();
		for (int phase = 2; phase < 4; phase++) begin
			set_idling(phase);
			write_reg(REG_HEADER_FIRST, 16'($urandom));
			write_reg(REG_HEADER_SECOND, 16'($urandom));
			write_reg(REG_POINTS, 16'($urandom_range(31)));
			write_reg(REG_MIN_RANGE, 16'($urandom_range(3000)));
			write_reg(REG_MAX_RANGE, 16'(($urandom_range(1)) ? 16'hffff : $urandom));
			send_byte(8'($urandom));
			send_byte(hdr_first_q);
			send_byte(8'($urandom));
			send_packet(rand_angle(), rand_angle(), $urandom_range(9) == 0, 1'b0);
			wait_idle();
		end
	endtask

	initial begin
		hdr_first_q = 8'd170;
		hdr_second_q = 8'd85;
		npts_q = 5'd16;
		min_mm_q = 16'd200;
		max_mm_q = 16'hffff;
		frame_pos = 0;
		sync_phase = PH_HUNT;
		sum_acc = '0;
		last_angle = '0;
		rev_count = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_config_extremes();
		test_random_traffic();
		in_done = 1'b1;
		if (expected_words.size() != 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			fail_count++;
		end
		$display("covered %0d bytes in %0d framed packets, %0d result words checked",
			bytes_sent, packets_sent, words_seen);
		$display("register sweeps included out-of-range point counts and range limits");
		if (fail_count == 0)
			$display("lidar_packet_deframer_tb OK");
		else
			$display("lidar_packet_deframer_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/lpd_pkg.sv
sv/lidar_packet_deframer.sv
sv/lpd_checker.sv
test/lidar_packet_deframer_tb.sv
